>>> sv/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int WORD_BITS      = 32;
    localparam int BLK_W          = 12;
    localparam int RESV_W         = 13;
    localparam int RESV_RESET     = 64;
    localparam int RESV_WORDS     = RESV_RESET / WORD_BITS;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RESERVED = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> sv/bba_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [bba_pkg::BLK_W-1:0] block_number;

    modport source (output valid, opcode, block_number, input ready);
    modport sink   (input valid, opcode, block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bba_pkg::BLK_W-1:0] allocated_block;
    logic [1:0]                status;

    modport source (output valid, allocated_block, status, input ready);
    modport sink   (input valid, allocated_block, status, output ready);
endinterface

interface bba_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::RESV_W-1:0] reserved_blocks;

    modport source (output valid, reserved_blocks, input ready);
    modport sink   (input valid, reserved_blocks, output ready);
endinterface

`default_nettype wire

>>> sv/block_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   word                                  accepted when
// i_req     in    opcode, block_number                  valid && ready
// o_rsp     out   allocated_block, status               valid && ready
// i_cfg     in    reserved_blocks                       valid && ready (ready always high)
//
// Free: bitmap read, modify/write, result. Allocate scans the bitmap RAM at
// one word a cycle and sets the first clear bit in the first word that has one;
// a full bitmap gives ST_FULL. After reset a clearing pass writes every bitmap
// word (the reserved words as used) before the first word is taken.
// A result waits in the output register while the next word is accepted.

module block_bitmap_allocator_unit #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bba_req_if.sink     i_req,
    bba_rsp_if.source   o_rsp,
    bba_cfg_if.sink     i_cfg
);

    localparam int NUM_WORDS = NUM_BLOCKS / bba_pkg::WORD_BITS;
    localparam int WW        = $clog2(NUM_WORDS);
    localparam int BW        = $clog2(bba_pkg::WORD_BITS);
    localparam int RW        = bba_pkg::BLK_W - BW;
    localparam logic [WW-1:0] LAST_WORD = WW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_PEND
    } t_state;

    t_state                      r_state;
    logic [WW-1:0]               r_clr_addr;
    logic [WW-1:0]               r_data_addr;
    logic [BW-1:0]               r_bit;
    logic                        r_free_wr;
    logic [bba_pkg::RESV_W-1:0]  r_resv;
    logic [bba_pkg::BLK_W-1:0]   r_res_blk;
    bba_pkg::t_status            r_res_st;
    logic                        r_out_valid;
    logic [bba_pkg::BLK_W-1:0]   r_out_blk;
    bba_pkg::t_status            r_out_st;

    logic [bba_pkg::WORD_BITS-1:0] r_bitmap [NUM_WORDS];
    logic [bba_pkg::WORD_BITS-1:0] r_rd_data;

    logic                          mem_we;
    logic [WW-1:0]                 mem_wa;
    logic [bba_pkg::WORD_BITS-1:0] mem_wd;
    logic                          mem_re;
    logic [WW-1:0]                 mem_ra;

    logic                          req_acc;
    logic                          req_free;
    logic [RW-1:0]                 req_word;
    logic                          req_in_range;
    logic                          req_refused;
    logic                          word_full;
    logic [BW-1:0]                 ffz;
    logic [WW+BW-1:0]              found_blk;

    assign req_acc      = i_req.valid && i_req.ready;
    assign req_free     = (i_req.opcode == bba_pkg::OP_FREE);
    assign req_word     = i_req.block_number[bba_pkg::BLK_W-1:BW];
    assign req_in_range = (32'(req_word) < NUM_WORDS);
    assign req_refused  = ({1'b0, i_req.block_number} < r_resv);
    assign word_full    = &r_rd_data;
    assign found_blk    = {r_data_addr, ffz};

    assign i_req.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.allocated_block = r_out_blk;
    assign o_rsp.status    = r_out_st;

    always_comb begin
        ffz = '0;
        for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--) begin
            if (!r_rd_data[j]) begin
                ffz = BW'(j);
            end
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_data_addr;
        mem_wd = r_rd_data;
        mem_re = 1'b0;
        mem_ra = WW'(r_data_addr + 1'b1);
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = (32'(r_clr_addr) < bba_pkg::RESV_WORDS) ? '1 : '0;
            end
            S_IDLE: begin
                if (req_acc) begin
                    mem_re = !req_free || req_in_range;
                    mem_ra = req_free ? WW'(req_word) : '0;
                end
            end
            S_FREE: begin
                mem_we = r_free_wr;
                mem_wd = r_rd_data & ~(bba_pkg::WORD_BITS'(1) << r_bit);
            end
            S_SCAN: begin
                if (!word_full) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data | (bba_pkg::WORD_BITS'(1) << ffz);
                end else if (r_data_addr != LAST_WORD) begin
                    mem_re = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_bitmap[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_resv      <= bba_pkg::RESV_W'(bba_pkg::RESV_RESET);
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_resv <= i_cfg.reserved_blocks;
            end
            if (r_out_valid && o_rsp.ready && r_state != S_PEND) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= WW'(r_clr_addr + 1'b1);
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_acc) begin
                        r_data_addr <= mem_ra;
                        r_bit       <= i_req.block_number[BW-1:0];
                        r_res_blk   <= '0;
                        if (req_free) begin
                            r_free_wr <= !req_refused && req_in_range;
                            r_res_st  <= req_refused ? bba_pkg::ST_RESERVED
                                                     : bba_pkg::ST_OK;
                            r_state   <= S_FREE;
                        end else begin
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_FREE: begin
                    r_state <= S_PEND;
                end
                S_SCAN: begin
                    if (!word_full) begin
                        r_res_blk <= bba_pkg::BLK_W'(found_blk);
                        r_res_st  <= bba_pkg::ST_OK;
                        r_state   <= S_PEND;
                    end else if (r_data_addr == LAST_WORD) begin
                        r_res_blk <= '0;
                        r_res_st  <= bba_pkg::ST_FULL;
                        r_state   <= S_PEND;
                    end else begin
                        r_data_addr <= mem_ra;
                    end
                end
                S_PEND: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_blk   <= r_res_blk;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_refused_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != bba_pkg::ST_OK) |-> (o_rsp.allocated_block == '0))
        else $error("nonzero block with error status");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_wa) < NUM_WORDS))
        else $error("bitmap write beyond last word");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && $past(r_state) == S_SCAN)
            |-> (r_data_addr == WW'($past(r_data_addr) + 1'b1)))
        else $error("scan skipped or repeated a word");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR || r_state == S_SCAN) |-> !i_req.ready)
        else $error("request taken while bitmap busy");
`endif

endmodule

`default_nettype wire

>>> dv/block_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_tb;
    import bba_pkg::*;

    localparam int MAP_WORDS = NUM_BLOCKS_DEF / WORD_BITS;
    localparam logic [10:0] STALL_PATTERN = 11'b10110111011;

    typedef struct packed {
        t_opcode          op;
        logic [BLK_W-1:0] blk;
    } t_request;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        t_status          status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();
    bba_cfg_if cfg_if ();

    block_bitmap_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    logic [RESV_W-1:0]    resv_limit;
    t_request             req_backlog [$];
    t_answer              answers_due [$];
    int                   fail_count;
    logic                 req_taken;
    int                   burst_left;
    int                   gap_left;
    logic [9:0]           stall_tick;
    t_request             next_req;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_answer serve_request(t_opcode op, logic [BLK_W-1:0] blk);
        t_answer a;
        bit      found;
        a.block = '0;
        a.status = ST_OK;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            for (int w = 0; w < MAP_WORDS && !found; w++) begin
                if (used_map[w] != '1) begin
                    for (int j = 0; j < WORD_BITS && !found; j++) begin
                        if (!used_map[w][j]) begin
                            used_map[w][j] = 1'b1;
                            a.block = BLK_W'(w * WORD_BITS + j);
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found) begin
                a.status = ST_FULL;
            end
        end else if ({1'b0, blk} < resv_limit) begin
            a.status = ST_RESERVED;
        end else if (int'(blk) / WORD_BITS < MAP_WORDS) begin
            used_map[int'(blk) / WORD_BITS][int'(blk) % WORD_BITS] = 1'b0;
        end
        return a;
    endfunction

    // sender: bursts of words separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && !(req_if.valid && !req_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                next_req = req_backlog.pop_front();
                req_if.valid <= 1'b1;
                req_if.opcode <= next_req.op;
                req_if.block_number <= next_req.blk;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall on a fixed pattern, with stretches of no stall
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 10'd1;
        rsp_if.ready <= (stall_tick[9:8] == 2'd0) || STALL_PATTERN[4'(stall_tick % 10'd11)];
    end

    always @(posedge i_clk) begin
        t_answer want;
        req_taken <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                resv_limit = cfg_if.reserved_blocks;
            end
            if (req_if.valid && req_if.ready) begin
                answers_due.push_back(serve_request(t_opcode'(req_if.opcode),
                                                    req_if.block_number));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected word block %0d status %0d",
                                 $time, rsp_if.allocated_block, rsp_if.status);
                    end
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_if.allocated_block !== want.block
                            || rsp_if.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: block exp %0d got %0d, status exp %0d got %0d",
                                     $time, want.block, rsp_if.allocated_block,
                                     want.status, rsp_if.status);
                        end
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_if.valid || answers_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_limit(int value);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.reserved_blocks <= RESV_W'(value);
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic push_req(t_opcode op, int blk);
        t_request r;
        r.op = op;
        r.blk = BLK_W'(blk);
        req_backlog.push_back(r);
    endtask

    task automatic queue_random(int count, int alloc_pct, int low_span);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                push_req(OP_ALLOC, $urandom_range(0, 4095));
            end else if ($urandom_range(0, 4) != 0) begin
                push_req(OP_FREE, $urandom_range(0, low_span));
            end else begin
                push_req(OP_FREE, $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        #50000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_ALLOC;
        req_if.block_number = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.reserved_blocks = '0;
        req_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_tick = '0;
        fail_count = 0;
        resv_limit = RESV_W'(RESV_RESET);
        for (int w = 0; w < MAP_WORDS; w++) begin
            used_map[w] = '0;
        end
        for (int b = 0; b < RESV_RESET; b++) begin
            used_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_req(OP_ALLOC, 0);
        push_req(OP_ALLOC, 4095);
        push_req(OP_FREE, RESV_RESET - 1);
        push_req(OP_FREE, 0);
        push_req(OP_FREE, RESV_RESET);
        push_req(OP_FREE, RESV_RESET);
        push_req(OP_ALLOC, 0);
        push_req(OP_FREE, 4095);
        push_req(OP_FREE, RESV_RESET + 1);
        push_req(OP_ALLOC, 2730);
        push_req(OP_FREE, 4094);
        push_req(OP_FREE, 1365);
        push_req(OP_ALLOC, 1365);

        set_limit(0);
        push_req(OP_FREE, 0);
        push_req(OP_FREE, RESV_RESET - 1);
        push_req(OP_ALLOC, 4095);
        push_req(OP_ALLOC, 0);
        queue_random(300, 55, 300);

        set_limit($urandom_range(1, 4095));
        queue_random(300, 50, 600);

        set_limit(4096);
        push_req(OP_FREE, 4095);
        queue_random(200, 70, 4095);

        set_limit($urandom_range(0, 128));
        queue_random(400, 50, 4095);

        set_limit(RESV_RESET);
        queue_random(300, 35, 4095);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && answers_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
